// ===== rtl/core/thsh_pkg.sv =====
// Constants, stage types and per-stage step functions for the thermistor
// Steinhart-Hart converter pipeline. No dependencies.
`default_nettype none

package thsh_pkg;

  // Divider network and fixed-point coefficients
  localparam logic [23:0] DIV_NUM    = 24'd10230000;
  localparam logic [23:0] R_SERIES   = 24'd10000;
  localparam logic [32:0] COEF_A_Q40 = 33'd1241511355;
  localparam logic [27:0] COEF_B_Q40 = 28'd257423160;
  localparam logic [16:0] COEF_C_Q40 = 17'd96399;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [60:0] LN_ROUND   = 61'd2147483648;
  // 100 * 2^40 shifted right by the 17 quotient bits
  localparam logic [32:0] CENTI_HI   = 33'd838860800;
  localparam logic signed [18:0] ZERO_C_CENTI = 19'sd27315;
  localparam logic signed [18:0] TEMP_MAX     = 19'sd40000;
  localparam logic signed [18:0] TEMP_MIN     = -19'sd10000;

  // Pipeline geometry
  localparam int DA_BPS = 3;    // quotient bits per resistance-divide stage
  localparam int DA_STG = 8;    // 24 quotient bits
  localparam int LG_STG = 24;   // one squaring per stage
  localparam int DB_STG = 17;   // one quotient bit per stage
  localparam int LATENCY = DA_STG + LG_STG + DB_STG + 9;

  typedef struct packed {
    logic        vld;
    logic [9:0]  code;
    logic [9:0]  rem;
    logic [23:0] q;
    logic [23:0] num;
  } da_t;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [23:0] r;
  } rs_t;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [4:0]  e;
    logic [30:0] m;
    logic [23:0] frac;
  } lg_t;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [28:0] lnr;
  } ln_t;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [28:0] lnr;
    logic [33:0] l2;
    logic [32:0] bl;
  } m1_t;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [38:0] l3;
    logic [32:0] bl;
  } m2_t;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [31:0] cl;
    logic [32:0] bl;
  } m3_t;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [32:0] s;
    logic [32:0] rem;
    logic [16:0] q;
  } db_t;

  // Retire DA_BPS quotient bits of DIV_NUM / code
  function automatic da_t da_step(input da_t s);
    da_t         o;
    logic [10:0] t;
    o = s;
    for (int j = 0; j < DA_BPS; j++) begin
      t     = {o.rem, o.num[23]};
      o.num = {o.num[22:0], 1'b0};
      if (t >= {1'b0, o.code}) begin
        t   = t - {1'b0, o.code};
        o.q = {o.q[22:0], 1'b1};
      end else begin
        o.q = {o.q[22:0], 1'b0};
      end
      o.rem = t[9:0];
    end
    return o;
  endfunction

  // Square the Q1.30 mantissa and emit one fraction bit of log2
  function automatic lg_t lg_step(input lg_t s);
    lg_t         o;
    logic [61:0] p;
    logic [31:0] sq;
    o      = s;
    p      = s.m * s.m;
    sq     = p[61:30];
    o.frac = {s.frac[22:0], sq[31]};
    o.m    = sq[31] ? sq[31:1] : sq[30:0];
    return o;
  endfunction

  // One restoring step of 100*2^40 / S
  function automatic db_t db_step(input db_t s);
    db_t         o;
    logic [33:0] t;
    o = s;
    t = {s.rem, 1'b0};
    if (t >= {1'b0, s.s}) begin
      t   = t - {1'b0, s.s};
      o.q = {s.q[15:0], 1'b1};
    end else begin
      o.q = {s.q[15:0], 1'b0};
    end
    o.rem = t[32:0];
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/thermistor_steinhart_hart_celsius.sv =====
// Thermistor ADC code to centi-degree Celsius converter, fully pipelined.
// Depends on thsh_pkg for constants, stage types and step functions.
//
//   channel   ports                                   transfer
//   input     start, busy, in_adc_code                start high, busy low
//   result    out_strobe, out_temp_centi_c,           out_strobe high
//             out_valid_res
//
// One code enters per cycle and results leave in input order. The depth is
// set by the 8-stage quotient divider (3 bits per stage), 24 log2 squaring
// stages and the 17-stage reciprocal divider, plus nine capture, arithmetic
// and output stages.
// busy is always low: the pipeline never stalls and the receiver cannot stall.
// Synchronous active-low reset clears all stage valid bits.
`default_nettype none

module thermistor_steinhart_hart_celsius
  import thsh_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [9:0]         in_adc_code,
  output logic                    out_strobe,
  output logic signed [16:0]      out_temp_centi_c,
  output logic                    out_valid_res
);

  da_t da_r [DA_STG+1];
  rs_t rs_r;
  lg_t lg_r [LG_STG+1];
  ln_t ln_r;
  m1_t m1_r;
  m2_t m2_r;
  m3_t m3_r;
  db_t db_r [DB_STG+1];

  assign busy = 1'b0;

  // Capture the code and seed the resistance divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      da_r[0] <= '0;
    end else begin
      da_r[0].vld  <= start;
      da_r[0].code <= in_adc_code;
      da_r[0].rem  <= '0;
      da_r[0].q    <= '0;
      da_r[0].num  <= DIV_NUM;
    end
  end

  // Advance the resistance divider
  for (genvar k = 0; k < DA_STG; k++) begin : g_da
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        da_r[k+1] <= '0;
      end else begin
        da_r[k+1] <= da_step(da_r[k]);
      end
    end
  end

  // Subtract the series resistor and flag codes without a positive resistance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= '0;
    end else begin
      rs_r.vld <= da_r[DA_STG].vld;
      rs_r.ok  <= (da_r[DA_STG].code != 10'd0) && (da_r[DA_STG].q > R_SERIES);
      rs_r.r   <= da_r[DA_STG].q - R_SERIES;
    end
  end

  // Normalize: find the leading one and shift the mantissa into Q1.30
  logic [4:0] lead_e;
  always_comb begin
    lead_e = '0;
    for (int i = 1; i < 24; i++) begin
      if (rs_r.r[i]) lead_e = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r[0] <= '0;
    end else begin
      lg_r[0].vld  <= rs_r.vld;
      lg_r[0].ok   <= rs_r.ok;
      lg_r[0].e    <= lead_e;
      lg_r[0].m    <= 31'(rs_r.r) << (5'd30 - lead_e);
      lg_r[0].frac <= '0;
    end
  end

  // Advance the log2 squaring chain
  for (genvar k = 0; k < LG_STG; k++) begin : g_lg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lg_r[k+1] <= '0;
      end else begin
        lg_r[k+1] <= lg_step(lg_r[k]);
      end
    end
  end

  // Convert log2 to ln with round half up
  logic [60:0] ln_prod;
  assign ln_prod = {lg_r[LG_STG].e, lg_r[LG_STG].frac} * LN2_Q32 + LN_ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ln_r <= '0;
    end else begin
      ln_r.vld <= lg_r[LG_STG].vld;
      ln_r.ok  <= lg_r[LG_STG].ok;
      ln_r.lnr <= ln_prod[60:32];
    end
  end

  // Form ln^2 and B*ln
  logic [57:0] l2_prod;
  logic [56:0] bl_prod;
  assign l2_prod = ln_r.lnr * ln_r.lnr;
  assign bl_prod = COEF_B_Q40 * ln_r.lnr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= '0;
    end else begin
      m1_r.vld <= ln_r.vld;
      m1_r.ok  <= ln_r.ok;
      m1_r.lnr <= ln_r.lnr;
      m1_r.l2  <= l2_prod[57:24];
      m1_r.bl  <= bl_prod[56:24];
    end
  end

  // Form ln^3
  logic [62:0] l3_prod;
  assign l3_prod = m1_r.l2 * m1_r.lnr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_r <= '0;
    end else begin
      m2_r.vld <= m1_r.vld;
      m2_r.ok  <= m1_r.ok;
      m2_r.l3  <= l3_prod[62:24];
      m2_r.bl  <= m1_r.bl;
    end
  end

  // Form C*ln^3
  logic [55:0] cl_prod;
  assign cl_prod = COEF_C_Q40 * m2_r.l3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_r <= '0;
    end else begin
      m3_r.vld <= m2_r.vld;
      m3_r.ok  <= m2_r.ok;
      m3_r.cl  <= cl_prod[55:24];
      m3_r.bl  <= m2_r.bl;
    end
  end

  // Sum the coefficient terms and seed the reciprocal divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_r[0] <= '0;
    end else begin
      db_r[0].vld <= m3_r.vld;
      db_r[0].ok  <= m3_r.ok;
      db_r[0].s   <= COEF_A_Q40 + m3_r.bl + 33'(m3_r.cl);
      db_r[0].rem <= CENTI_HI;
      db_r[0].q   <= '0;
    end
  end

  // Advance the reciprocal divider
  for (genvar k = 0; k < DB_STG; k++) begin : g_db
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        db_r[k+1] <= '0;
      end else begin
        db_r[k+1] <= db_step(db_r[k]);
      end
    end
  end

  // Offset to Celsius, truncate toward zero and saturate; invalid results read zero
  logic signed [18:0] quo_s;
  logic signed [18:0] temp_nxt;
  always_comb begin
    quo_s = signed'({2'b00, db_r[DB_STG].q});
    if (quo_s >= ZERO_C_CENTI) begin
      temp_nxt = quo_s - ZERO_C_CENTI;
      if (temp_nxt > TEMP_MAX) temp_nxt = TEMP_MAX;
    end else begin
      temp_nxt = quo_s - ZERO_C_CENTI
               + ((db_r[DB_STG].rem != '0) ? 19'sd1 : 19'sd0);
      if (temp_nxt < TEMP_MIN) temp_nxt = TEMP_MIN;
    end
    if (!db_r[DB_STG].ok) temp_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= db_r[DB_STG].vld;
    end
  end

  always_ff @(posedge clk) begin
    out_temp_centi_c <= temp_nxt[16:0];
    out_valid_res    <= db_r[DB_STG].ok;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_strobe)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##LATENCY !out_strobe)
    else $error("result without a transfer");

  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_adc_code == 10'd0) |-> ##LATENCY !out_valid_res)
    else $error("zero code reported valid");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |-> (out_temp_centi_c == 17'sd0))
    else $error("invalid result not zero");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_temp_centi_c >= -17'sd10000 && out_temp_centi_c <= 17'sd40000))
    else $error("temperature out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/thermistor_steinhart_hart_celsius_tb.sv =====
// Testbench for thermistor_steinhart_hart_celsius: ADC code transfers checked
// against a fixed-point Steinhart-Hart predictor. Depends on thsh_pkg.
`timescale 1ns / 100ps

module thermistor_steinhart_hart_celsius_tb;
  import thsh_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_CODES = 1700;

  typedef struct {
    int                 code;
    bit                 known;
    logic signed [16:0] temp;
    logic               ok;
  } code_row_t;

  typedef struct {
    logic signed [16:0] temp;
    logic               ok;
  } reading_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [9:0]        in_adc_code;
  logic              out_strobe;
  logic signed [16:0] out_temp_centi_c;
  logic              out_valid_res;

  reading_t          pending_readings[$];
  longint unsigned   cycle_count;
  int                errors;
  int                codes_sent;
  int                readings_checked;
  int                invalid_seen;
  int                saturated_seen;
  int                idle_pct;

  thermistor_steinhart_hart_celsius DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_adc_code      (in_adc_code),
    .out_strobe       (out_strobe),
    .out_temp_centi_c (out_temp_centi_c),
    .out_valid_res    (out_valid_res)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Temperature in centi-degrees from one ADC code, fixed point throughout
  function automatic reading_t celsius_from_code(input logic [9:0] code);
    reading_t          rd;
    longint unsigned   quot, ohms, expo, mant, frac, lg2, lnr, l2, l3, sum;
    longint unsigned   kel, kel_rem;
    longint            t;
    rd.temp = '0;
    rd.ok   = 1'b0;
    if (code == 10'd0) return rd;
    quot = 64'd10230000 / code;
    if (quot <= 64'd10000) return rd;
    ohms  = quot - 64'd10000;
    rd.ok = 1'b1;
    // log2: integer part from the top set bit, fraction by repeated squaring
    expo = 0;
    while (expo < 31 && (ohms >> (expo + 1)) != 0) expo++;
    mant = ohms << (30 - expo);
    frac = 0;
    for (int i = 0; i < 24; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd1 << 31)) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    lg2 = (expo << 24) | frac;
    lnr = (lg2 * 64'd2977044472 + (64'd1 << 31)) >> 32;
    l2  = (lnr * lnr) >> 24;
    l3  = (l2 * lnr) >> 24;
    sum = 64'd1241511355 + ((64'd257423160 * lnr) >> 24) + ((64'd96399 * l3) >> 24);
    kel     = (64'd100 << 40) / sum;
    kel_rem = (64'd100 << 40) % sum;
    // truncate toward zero on both sides of the ice point
    if (kel >= 64'd27315) t = longint'(kel) - 27315;
    else t = longint'(kel) + (kel_rem != 0 ? 1 : 0) - 27315;
    if (t > 40000) t = 40000;
    if (t < -10000) t = -10000;
    rd.temp = t[16:0];
    return rd;
  endfunction

  // Drive one code and hold it until the transfer, then log its expectation
  task automatic send_code(input logic [9:0] code, input bit known,
                           input reading_t typed);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_adc_code <= code;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    pending_readings.push_back(known ? typed : celsius_from_code(code));
    codes_sent++;
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_strobe) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result temp=%0d valid=%0b", $time,
                 out_temp_centi_c, out_valid_res);
        errors <= errors + 1;
      end else begin
        if (out_temp_centi_c !== pending_readings[0].temp ||
            out_valid_res !== pending_readings[0].ok) begin
          $display("%0t: mismatch expected temp=%0d valid=%0b, got temp=%0d valid=%0b",
                   $time, pending_readings[0].temp, pending_readings[0].ok,
                   out_temp_centi_c, out_valid_res);
          errors <= errors + 1;
        end
        if (!pending_readings[0].ok) invalid_seen <= invalid_seen + 1;
        if (pending_readings[0].temp == 17'sd40000 ||
            pending_readings[0].temp == -17'sd10000)
          saturated_seen <= saturated_seen + 1;
        readings_checked <= readings_checked + 1;
        pending_readings.pop_front();
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("thermistor_steinhart_hart_celsius_tb NOT OK");
      $finish;
    end
  end

  initial begin
    code_row_t dir_rows[$];
    reading_t  typed;
    errors           = 0;
    codes_sent       = 0;
    readings_checked = 0;
    invalid_seen     = 0;
    saturated_seen   = 0;
    cycle_count      = 0;
    idle_pct         = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_adc_code = '0;
    // zero code and the top code give no resistance; the rest span the curve
    dir_rows = '{
      '{0,    1, 17'sd0, 1'b0}, '{1023, 1, 17'sd0, 1'b0},
      '{1,    0, 17'sd0, 1'b0}, '{2,    0, 17'sd0, 1'b0},
      '{3,    0, 17'sd0, 1'b0}, '{7,    0, 17'sd0, 1'b0},
      '{31,   0, 17'sd0, 1'b0}, '{128,  0, 17'sd0, 1'b0},
      '{341,  0, 17'sd0, 1'b0}, '{511,  0, 17'sd0, 1'b0},
      '{512,  0, 17'sd0, 1'b0}, '{682,  0, 17'sd0, 1'b0},
      '{900,  0, 17'sd0, 1'b0}, '{1000, 0, 17'sd0, 1'b0},
      '{1017, 0, 17'sd0, 1'b0}, '{1018, 0, 17'sd0, 1'b0},
      '{1021, 0, 17'sd0, 1'b0}, '{1022, 0, 17'sd0, 1'b0},
      '{682,  0, 17'sd0, 1'b0}, '{0,    1, 17'sd0, 1'b0},
      '{1022, 0, 17'sd0, 1'b0}, '{1,    0, 17'sd0, 1'b0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed codes back to back
    foreach (dir_rows[i]) begin
      typed.temp = dir_rows[i].temp;
      typed.ok   = dir_rows[i].ok;
      send_code(dir_rows[i].code[9:0], dir_rows[i].known, typed);
    end

    // random codes: light sender gaps, heavy gaps, then none
    for (int i = 0; i < RANDOM_CODES; i++) begin
      idle_pct = (i < RANDOM_CODES / 3) ? 9 : (i < 2 * RANDOM_CODES / 3) ? 52 : 0;
      send_code(10'($urandom_range(0, 1023)), 1'b0, typed);
    end
    start <= 1'b0;

    // drain the pipeline, then allow extra cycles for stray strobes
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d ADC codes, checked %0d readings (%0d invalid, %0d clamped).",
             codes_sent, readings_checked, invalid_seen, saturated_seen);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("thermistor_steinhart_hart_celsius_tb OK");
    end else begin
      $display("thermistor_steinhart_hart_celsius_tb NOT OK");
    end
    $finish;
  end

endmodule
